>>> sv/gaussian_mixture_background_update_defines.svh
// Assertion macros shared by the background update RTL.
`ifndef GAUSSIAN_MIXTURE_BACKGROUND_UPDATE_DEFINES_SVH
`define GAUSSIAN_MIXTURE_BACKGROUND_UPDATE_DEFINES_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define GMBU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define GMBU_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define GMBU_ASSERT(label, clk, rstn, prop, msg)
`define GMBU_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

>>> sv/gmbu_pkg.sv
// Types and constants of the mixture-of-Gaussians background update.
package gmbu_pkg;

    localparam int DEF_PIXELS    = 65536;
    localparam int DEF_GAUSSIANS = 3;

    localparam int          EXP_STEPS    = 3072;
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4278222805;
    localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
    localparam logic [24:0] RATE_ONE     = 25'd16777216;
    localparam logic [23:0] NEW_VARIANCE = 24'd12800;
    localparam logic [15:0] NEW_WEIGHT   = 16'd6554;

    localparam logic [15:0] RST_LEARNING_RATE     = 16'd655;
    localparam logic [11:0] RST_MATCH_SIGMAS      = 12'd640;
    localparam logic [15:0] RST_BACKGROUND_WEIGHT = 16'd45875;
    localparam logic [23:0] RST_VARIANCE_FLOOR    = 24'd1024;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    typedef enum logic [1:0] {
        CFG_LEARNING_RATE     = 2'd0,
        CFG_MATCH_SIGMAS      = 2'd1,
        CFG_BACKGROUND_WEIGHT = 2'd2,
        CFG_VARIANCE_FLOOR    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] weight;
        logic [23:0] variance;
        logic [15:0] mean;
    } gauss_t;

endpackage

>>> sv/gaussian_mixture_background_update.sv
// Top level: per-pixel mixture-of-Gaussians background classifier and model update.
//
//  channel  direction  handshake           payload
//  s_       in         s_tvalid/s_tready   s_tdata pixel and load fields, s_tuser op
//  m_       out        m_tvalid/m_tready   m_tdata foreground, matched, result_index
//  cfg_     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A load is written in the cycle that accepts it. A classify reads each of the pixel's
// Gaussians through S_RD, S_MUL and S_CMP, then, when one matches, runs a 12-step divider,
// a 22-step square root, a ROM read and a 24-step divider for the rate, the mean and
// variance arithmetic (S_MEAN1, S_MEAN2, S_VAR1 to S_VAR3) and a weight multiply and a
// write per Gaussian before the result; when none matches, the weakest one is replaced.
// Reset fills the 3072-entry exp ROM, one multiply and one add per entry; no
// transaction is accepted then, configuration writes are taken as ever.
// A finished result waits in the output register; processing of the next pixel stalls
// only when a second result is ready before the first is taken.
`include "gaussian_mixture_background_update_defines.svh"
module gaussian_mixture_background_update
    import gmbu_pkg::*;
#(
    parameter int PIXELS    = DEF_PIXELS,
    parameter int GAUSSIANS = DEF_GAUSSIANS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_index[15:0], pixel_value[23:16], gauss_index[26:24], load_mean[42:27],
    // load_variance[66:43], load_weight[82:67], zero pad[87:83]
    input  logic [87:0] s_tdata,
    // op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // foreground[0], matched[1], result_index[17:2], zero pad[23:18]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int ENTRIES = PIXELS * GAUSSIANS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int GW      = (GAUSSIANS > 1) ? $clog2(GAUSSIANS) : 1;
    localparam int XW      = $clog2(EXP_STEPS);

    typedef enum logic [4:0] {
        S_INIT_MUL, S_INIT_ADD, S_IDLE, S_RD, S_MUL, S_CMP, S_QINIT, S_QDIV,
        S_SQRT, S_EXP, S_RNUM, S_RINIT, S_RDIV, S_MEAN1, S_MEAN2, S_VAR1,
        S_VAR2, S_VAR3, S_WMUL, S_WWR, S_REPL, S_RES
    } state_t;

    // input field slices
    logic [15:0] in_pix;
    logic [7:0]  in_val;
    logic [2:0]  in_gi;
    gauss_t      in_load;
    assign in_pix           = s_tdata[15:0];
    assign in_val           = s_tdata[23:16];
    assign in_gi            = s_tdata[26:24];
    assign in_load.mean     = s_tdata[42:27];
    assign in_load.variance = s_tdata[66:43];
    assign in_load.weight   = s_tdata[82:67];

    // configuration
    logic [15:0] learning_rate_reg;
    logic [11:0] match_sigmas_reg;
    logic [15:0] background_weight_reg;
    logic [23:0] variance_floor_reg;
    logic [23:0] k2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learning_rate_reg     <= RST_LEARNING_RATE;
            match_sigmas_reg      <= RST_MATCH_SIGMAS;
            background_weight_reg <= RST_BACKGROUND_WEIGHT;
            variance_floor_reg    <= RST_VARIANCE_FLOOR;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LEARNING_RATE:     learning_rate_reg     <= cfg_data[15:0];
                CFG_MATCH_SIGMAS:      match_sigmas_reg      <= cfg_data[11:0];
                CFG_BACKGROUND_WEIGHT: background_weight_reg <= cfg_data[15:0];
                CFG_VARIANCE_FLOOR:    variance_floor_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // k squared, settled long before the first match test of a transaction
    always_ff @(posedge aclk) begin
        k2_reg <= match_sigmas_reg * match_sigmas_reg;
    end

    // control and datapath registers
    state_t        state_reg;
    logic [GW-1:0] g_reg;
    logic [AW-1:0] base_reg;
    logic [15:0]   pix_reg;
    logic [7:0]    val_reg;
    gauss_t        rd_q_reg;

    logic [15:0]   mean_arr_reg [GAUSSIANS];
    logic [23:0]   var_arr_reg  [GAUSSIANS];
    logic [15:0]   w_arr_reg    [GAUSSIANS];

    logic [15:0]   cur_w_reg;
    logic [15:0]   cur_mean_reg;
    logic [23:0]   cur_var_reg;
    logic [31:0]   dd_reg;
    logic [47:0]   kv_reg;
    logic [39:0]   lhs_reg;
    logic [39:0]   rhs_reg;

    logic          found_reg;
    logic [GW-1:0] best_reg;
    logic [15:0]   best_w_reg;
    logic [15:0]   best_mean_reg;
    logic [23:0]   best_var_reg;
    logic [31:0]   best_dd_reg;
    logic [GW-1:0] low_reg;
    logic [15:0]   low_w_reg;
    logic [23:0]   low_v_reg;

    logic [4:0]    cnt_reg;
    logic          q_sat_reg;
    logic [31:0]   q_rem_reg;
    logic [XW-1:0] q_reg;
    logic [43:0]   sq_n_reg;
    logic [43:0]   root_reg;
    logic [16:0]   rom_q_reg;
    logic [36:0]   num_reg;
    logic          r_sat_reg;
    logic [36:0]   r_rem_reg;
    logic [23:0]   r_q_reg;
    logic [40:0]   pa_reg;
    logic [40:0]   pb_reg;
    logic [15:0]   nm_reg;
    logic [31:0]   dn_reg;
    logic [48:0]   t1_reg;
    logic [56:0]   t2_reg;
    logic [23:0]   nv_reg;
    logic [32:0]   wp_reg;

    logic [32:0]   e_reg;
    logic [48:0]   prod_hi_reg;
    logic [47:0]   prod_lo_reg;
    logic [XW-1:0] init_idx_reg;

    logic          m_tvalid_reg;
    logic [23:0]   m_tdata_reg;

    // combinational helpers
    logic [15:0] x_q;
    logic [15:0] d_abs;
    logic [15:0] dn_abs;
    logic        hit_c;
    logic        better_c;
    logic        weaker_c;
    logic [35:0] q_trial;
    logic        q_take;
    logic [43:0] sq_bit;
    logic        sq_take;
    logic [21:0] s_val;
    logic [16:0] e_val;
    logic [45:0] r_trial;
    logic        r_take;
    logic [24:0] r_c;
    logic [24:0] one_minus_r;
    logic [41:0] nm_sum;
    logic [57:0] nv_sum;
    logic [25:0] nv_full;
    logic [23:0] nv_sat;
    logic [33:0] nw_sum;
    logic [17:0] nw_full;
    logic [15:0] nw_val;
    logic [64:0] e_sum;
    logic [33:0] rom_wsum;
    logic        in_range;
    logic        load_ok;
    logic        accept;
    logic        res_free;

    assign x_q      = {val_reg, 8'd0};
    assign d_abs    = (x_q >= rd_q_reg.mean) ? x_q - rd_q_reg.mean : rd_q_reg.mean - x_q;
    assign dn_abs   = (x_q >= nm_reg) ? x_q - nm_reg : nm_reg - x_q;
    assign hit_c    = {8'd0, dd_reg, 8'd0} < kv_reg;
    assign better_c = hit_c && (!found_reg || cur_w_reg > best_w_reg);
    assign weaker_c = (g_reg != '0) && (lhs_reg < rhs_reg);

    assign q_trial  = {11'd0, best_var_reg, 1'b0} << cnt_reg;
    assign q_take   = {4'd0, q_rem_reg} >= q_trial;

    assign sq_bit   = 44'd1 << {cnt_reg, 1'b0};
    assign sq_take  = sq_n_reg >= root_reg + sq_bit;
    assign s_val    = root_reg[21:0];

    assign e_val    = q_sat_reg ? 17'd0 : rom_q_reg;
    assign r_trial  = 46'(s_val) << cnt_reg;
    assign r_take   = {9'd0, r_rem_reg} >= r_trial;
    assign r_c      = r_sat_reg ? RATE_ONE : {1'b0, r_q_reg};
    assign one_minus_r = RATE_ONE - r_c;

    assign nm_sum   = 42'(pa_reg) + 42'(pb_reg) + 42'd8388608;
    assign nv_sum   = {1'b0, t1_reg, 8'd0} + 58'(t2_reg) + 58'd2147483648;
    assign nv_full  = nv_sum[57:32];
    assign nv_sat   = (nv_full > 26'hFFFFFF) ? 24'hFFFFFF : nv_full[23:0];

    assign nw_sum   = 34'(wp_reg) + 34'd32768
                    + ((g_reg == best_reg) ? {2'd0, learning_rate_reg, 16'd0} : 34'd0);
    assign nw_full  = nw_sum[33:16];
    assign nw_val   = (nw_full > 18'hFFFF) ? 16'hFFFF : nw_full[15:0];

    assign e_sum    = {prod_hi_reg, 16'd0} + 65'(prod_lo_reg) + 65'd2147483648;
    assign rom_wsum = 34'(e_reg) + 34'd32768;

    assign in_range = 32'(in_pix) < 32'(PIXELS);
    assign load_ok  = in_range && (32'(in_gi) < 32'(GAUSSIANS));
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign res_free = !m_tvalid_reg || m_tready;

    // state memory: one entry per Gaussian, entry pixel*GAUSSIANS+g
    gauss_t        gauss_mem [ENTRIES];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    gauss_t        wr_data;
    logic [AW-1:0] rd_addr;

    assign rd_addr = base_reg + AW'(g_reg);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = base_reg + AW'(g_reg);
        wr_data = in_load;
        if (state_reg == S_IDLE) begin
            wr_en   = accept && (s_tuser == OP_LOAD) && load_ok;
            wr_addr = AW'(32'(in_pix) * 32'(GAUSSIANS) + 32'(in_gi));
        end else if (state_reg == S_WWR) begin
            wr_en = 1'b1;
            wr_data.weight   = nw_val;
            wr_data.variance = (g_reg == best_reg) ? nv_reg : var_arr_reg[g_reg];
            wr_data.mean     = (g_reg == best_reg) ? nm_reg : mean_arr_reg[g_reg];
        end else if (state_reg == S_REPL) begin
            wr_en   = 1'b1;
            wr_addr = base_reg + AW'(low_reg);
            wr_data.mean     = x_q;
            wr_data.variance = NEW_VARIANCE;
            wr_data.weight   = NEW_WEIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            gauss_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= gauss_mem[rd_addr];
    end

    // exp(-q/256) table, Q1.16, filled after reset
    logic [16:0] exp_rom [EXP_STEPS];

    always_ff @(posedge aclk) begin
        if (state_reg == S_INIT_MUL) begin
            exp_rom[init_idx_reg] <= rom_wsum[32:16];
        end
        rom_q_reg <= exp_rom[q_reg];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT_MUL;
            init_idx_reg <= '0;
            e_reg        <= 33'h100000000;
            m_tvalid_reg <= 1'b0;
        end else begin
            // drop a taken result; the result state reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != S_RES) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT_MUL: begin
                    prod_hi_reg <= e_reg[32:16] * EXP_STEP_Q32;
                    prod_lo_reg <= e_reg[15:0] * EXP_STEP_Q32;
                    state_reg   <= S_INIT_ADD;
                end
                S_INIT_ADD: begin
                    e_reg <= e_sum[64:32];
                    if (init_idx_reg == XW'(EXP_STEPS - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        init_idx_reg <= init_idx_reg + 1'b1;
                        state_reg    <= S_INIT_MUL;
                    end
                end
                S_IDLE: begin
                    if (accept && s_tuser == OP_CLASSIFY && in_range) begin
                        pix_reg   <= in_pix;
                        val_reg   <= in_val;
                        base_reg  <= AW'(32'(in_pix) * 32'(GAUSSIANS));
                        g_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    cur_w_reg    <= rd_q_reg.weight;
                    cur_mean_reg <= rd_q_reg.mean;
                    cur_var_reg  <= rd_q_reg.variance;
                    mean_arr_reg[g_reg] <= rd_q_reg.mean;
                    var_arr_reg[g_reg]  <= rd_q_reg.variance;
                    w_arr_reg[g_reg]    <= rd_q_reg.weight;
                    dd_reg  <= d_abs * d_abs;
                    kv_reg  <= k2_reg * rd_q_reg.variance;
                    lhs_reg <= rd_q_reg.weight * low_v_reg;
                    rhs_reg <= low_w_reg * rd_q_reg.variance;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (better_c) begin
                        found_reg     <= 1'b1;
                        best_reg      <= g_reg;
                        best_w_reg    <= cur_w_reg;
                        best_mean_reg <= cur_mean_reg;
                        best_var_reg  <= cur_var_reg;
                        best_dd_reg   <= dd_reg;
                    end
                    if (g_reg == '0 || weaker_c) begin
                        low_reg   <= g_reg;
                        low_w_reg <= cur_w_reg;
                        low_v_reg <= cur_var_reg;
                    end
                    if (g_reg == GW'(GAUSSIANS - 1)) begin
                        state_reg <= (found_reg || better_c) ? S_QINIT : S_REPL;
                    end else begin
                        g_reg     <= g_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_QINIT: begin
                    // q saturates once D reaches 3072 * 2V
                    q_sat_reg <= {5'd0, best_dd_reg}
                               >= ({1'b0, best_var_reg, 12'd0} + {2'd0, best_var_reg, 11'd0});
                    q_rem_reg <= best_dd_reg;
                    q_reg     <= '0;
                    sq_n_reg  <= 44'(best_var_reg) * 44'(TWO_PI_Q16);
                    cnt_reg   <= 5'(XW - 1);
                    state_reg <= S_QDIV;
                end
                S_QDIV: begin
                    if (q_take) begin
                        q_rem_reg <= q_rem_reg - q_trial[31:0];
                        q_reg[cnt_reg[3:0]] <= 1'b1;
                    end
                    if (cnt_reg == '0) begin
                        root_reg  <= '0;
                        cnt_reg   <= 5'd21;
                        state_reg <= S_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_SQRT: begin
                    if (sq_take) begin
                        sq_n_reg <= sq_n_reg - (root_reg + sq_bit);
                        root_reg <= (root_reg >> 1) + sq_bit;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    if (cnt_reg == '0) begin
                        state_reg <= S_EXP;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_EXP: begin
                    state_reg <= S_RNUM;
                end
                S_RNUM: begin
                    num_reg   <= {33'(learning_rate_reg) * 33'(e_val), 4'd0};
                    state_reg <= S_RINIT;
                end
                S_RINIT: begin
                    r_sat_reg <= {9'd0, num_reg} >= {s_val, 24'd0};
                    r_rem_reg <= num_reg;
                    r_q_reg   <= '0;
                    cnt_reg   <= 5'd23;
                    state_reg <= S_RDIV;
                end
                S_RDIV: begin
                    if (r_take) begin
                        r_rem_reg <= r_rem_reg - r_trial[36:0];
                        r_q_reg[cnt_reg] <= 1'b1;
                    end
                    if (cnt_reg == '0) begin
                        state_reg <= S_MEAN1;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_MEAN1: begin
                    pa_reg    <= one_minus_r * best_mean_reg;
                    pb_reg    <= r_c * x_q;
                    state_reg <= S_MEAN2;
                end
                S_MEAN2: begin
                    nm_reg    <= (nm_sum[41:24] > 18'hFFFF) ? 16'hFFFF : nm_sum[39:24];
                    state_reg <= S_VAR1;
                end
                S_VAR1: begin
                    dn_reg    <= dn_abs * dn_abs;
                    t1_reg    <= one_minus_r * best_var_reg;
                    state_reg <= S_VAR2;
                end
                S_VAR2: begin
                    t2_reg    <= r_c * dn_reg;
                    state_reg <= S_VAR3;
                end
                S_VAR3: begin
                    nv_reg    <= (nv_sat < variance_floor_reg) ? variance_floor_reg : nv_sat;
                    g_reg     <= '0;
                    state_reg <= S_WMUL;
                end
                S_WMUL: begin
                    wp_reg    <= (17'd65536 - 17'(learning_rate_reg)) * w_arr_reg[g_reg];
                    state_reg <= S_WWR;
                end
                S_WWR: begin
                    if (g_reg == GW'(GAUSSIANS - 1)) begin
                        state_reg <= S_RES;
                    end else begin
                        g_reg     <= g_reg + 1'b1;
                        state_reg <= S_WMUL;
                    end
                end
                S_REPL: begin
                    state_reg <= S_RES;
                end
                S_RES: begin
                    // hold the result until the output register is free
                    if (res_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, pix_reg, found_reg,
                                         !(found_reg && best_w_reg > background_weight_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `GMBU_ASSERT(a_result_from_res, aclk, aresetn,
        $rose(m_tvalid) |-> $past(state_reg == S_RES), "result raised outside result state")
    `GMBU_ASSERT(a_q_in_table, aclk, aresetn,
        (state_reg == S_EXP) |-> (q_sat_reg || q_reg < XW'(EXP_STEPS)), "exp index beyond table")
    `GMBU_ASSERT(a_root_nonzero, aclk, aresetn,
        (state_reg == S_EXP) |-> (s_val != '0), "zero square root for matched Gaussian")
    `GMBU_ASSERT(a_rate_bounded, aclk, aresetn,
        (state_reg == S_MEAN1) |-> (r_c <= RATE_ONE), "rate above one")
    `GMBU_NEVER(a_no_write_in_scan, aclk, aresetn,
        wr_en && (state_reg == S_RD || state_reg == S_MUL || state_reg == S_CMP),
        "state written during scan")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the mixture-of-Gaussians background update block.
`timescale 1ns / 100ps

typedef struct {
    logic        foreground;
    logic        matched;
    logic [15:0] index;
} mask_bit_t;

class mask_predictor;
    localparam int ENTRIES = gmbu_pkg::DEF_PIXELS * gmbu_pkg::DEF_GAUSSIANS;
    localparam int G       = gmbu_pkg::DEF_GAUSSIANS;

    logic [15:0] mean_mem[ENTRIES];
    logic [23:0] var_mem[ENTRIES];
    logic [15:0] weight_mem[ENTRIES];
    logic [16:0] exp_table[gmbu_pkg::EXP_STEPS];

    logic [15:0] rate_a;
    logic [11:0] sigmas_k;
    logic [15:0] bg_weight;
    logic [23:0] var_floor;

    mask_bit_t expected_masks[$];
    int        mismatches;

    function new();
        longint unsigned e;
        e = 64'd1 << 32;
        for (int i = 0; i < gmbu_pkg::EXP_STEPS; i++) begin
            exp_table[i] = 17'((e + 32768) >> 16);
            e = (e * 64'(gmbu_pkg::EXP_STEP_Q32) + (64'd1 << 31)) >> 32;
        end
        rate_a     = gmbu_pkg::RST_LEARNING_RATE;
        sigmas_k   = gmbu_pkg::RST_MATCH_SIGMAS;
        bg_weight  = gmbu_pkg::RST_BACKGROUND_WEIGHT;
        var_floor  = gmbu_pkg::RST_VARIANCE_FLOOR;
        mismatches = 0;
    endfunction

    function void write_reg(gmbu_pkg::cfg_reg_t idx, logic [23:0] value);
        case (idx)
            gmbu_pkg::CFG_LEARNING_RATE:     rate_a    = value[15:0];
            gmbu_pkg::CFG_MATCH_SIGMAS:      sigmas_k  = value[11:0];
            gmbu_pkg::CFG_BACKGROUND_WEIGHT: bg_weight = value[15:0];
            gmbu_pkg::CFG_VARIANCE_FLOOR:    var_floor = value;
        endcase
    endfunction

    function longint unsigned sq_dist(longint unsigned p, longint unsigned q);
        longint unsigned d;
        d = p >= q ? p - q : q - p;
        return d * d;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function void note_pixel(logic op, logic [15:0] pix, logic [7:0] x, logic [2:0] g,
                             logic [15:0] lm, logic [23:0] lv, logic [15:0] lw);
        int base, best, low, at;
        longint unsigned xq, k2, dd, m, v, q, e, s, r, nm, nv, dn, w, nw, a, lhs, rhs;
        mask_bit_t res;
        base = int'(pix) * G;
        if (op == gmbu_pkg::OP_LOAD) begin
            if (g < G) begin
                mean_mem[base + g]   = lm;
                var_mem[base + g]    = lv;
                weight_mem[base + g] = lw;
            end
            return;
        end
        xq   = longint'(x) << 8;
        a    = rate_a;
        k2   = longint'(sigmas_k) * sigmas_k;
        best = -1;
        for (int i = 0; i < G; i++) begin
            dd = sq_dist(xq, mean_mem[base + i]);
            if ((dd << 8) < k2 * var_mem[base + i])
                if (best < 0 || weight_mem[base + i] > weight_mem[base + best]) best = i;
        end
        res.index = pix;
        if (best >= 0) begin
            at = base + best;
            m  = mean_mem[at];
            v  = var_mem[at];
            dd = sq_dist(xq, m);
            q  = v != 0 ? dd / (2 * v) : gmbu_pkg::EXP_STEPS;
            e  = q < gmbu_pkg::EXP_STEPS ? exp_table[q] : 0;
            s  = root_floor(v * 64'(gmbu_pkg::TWO_PI_Q16));
            r  = s != 0 ? (a * e * 16) / s : 64'd1 << 24;
            if (r > (64'd1 << 24)) r = 64'd1 << 24;
            res.matched    = 1'b1;
            res.foreground = weight_mem[at] > bg_weight ? 1'b0 : 1'b1;
            nm = (((64'd1 << 24) - r) * m + r * xq + (64'd1 << 23)) >> 24;
            if (nm > 64'hFFFF) nm = 64'hFFFF;
            dn = sq_dist(xq, nm);
            nv = (((64'd1 << 24) - r) * (v << 8) + r * dn + (64'd1 << 31)) >> 32;
            if (nv > 64'hFFFFFF) nv = 64'hFFFFFF;
            if (nv < var_floor) nv = var_floor;
            mean_mem[at] = 16'(nm);
            var_mem[at]  = 24'(nv);
            for (int i = 0; i < G; i++) begin
                w  = weight_mem[base + i];
                nw = (65536 - a) * w + 32768;
                if (i == best) nw += a << 16;
                nw >>= 16;
                if (nw > 64'hFFFF) nw = 64'hFFFF;
                weight_mem[base + i] = 16'(nw);
            end
        end else begin
            // replace the weakest Gaussian, first one kept on ties
            low = 0;
            for (int i = 1; i < G; i++) begin
                lhs = longint'(weight_mem[base + i]) * var_mem[base + low];
                rhs = longint'(weight_mem[base + low]) * var_mem[base + i];
                if (lhs < rhs) low = i;
            end
            mean_mem[base + low]   = 16'(xq);
            var_mem[base + low]    = gmbu_pkg::NEW_VARIANCE;
            weight_mem[base + low] = gmbu_pkg::NEW_WEIGHT;
            res.matched    = 1'b0;
            res.foreground = 1'b1;
        end
        expected_masks.push_back(res);
    endfunction

    function void check_mask(logic [23:0] data);
        mask_bit_t exp_bit;
        if (expected_masks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected mask transaction %h", data);
            return;
        end
        exp_bit = expected_masks.pop_front();
        if (data[0] !== exp_bit.foreground || data[1] !== exp_bit.matched ||
            data[17:2] !== exp_bit.index) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mask mismatch: exp fg=%0d m=%0d idx=%0d, got fg=%0d m=%0d idx=%0d",
                         exp_bit.foreground, exp_bit.matched, exp_bit.index,
                         data[0], data[1], data[17:2]);
        end
    endfunction
endclass

module tb;
    import gmbu_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    mask_predictor model = new();

    bit quiet = 1'b0;      // no idling on either side
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off
    int sent = 0;
    longint cycles = 0;

    gaussian_mixture_background_update dut (.*);

    always #5 aclk = ~aclk;

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check each mask transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) model.check_mask(m_tdata);
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    // Offer one input transaction and hold it until it is taken.
    task automatic send_pixel(logic op, logic [15:0] pix, logic [7:0] x, logic [2:0] g,
                              logic [15:0] lm, logic [23:0] lv, logic [15:0] lw);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, lw, lv, lm, g, x, pix};
        do @(posedge aclk); while (!s_tready);
        model.note_pixel(op, pix, x, g, lm, lv, lw);
        sent++;
    endtask

    task automatic load_gauss(logic [15:0] pix, logic [2:0] g, logic [15:0] lm,
                              logic [23:0] lv, logic [15:0] lw);
        send_pixel(OP_LOAD, pix, 8'($urandom), g, lm, lv, lw);
    endtask

    task automatic classify(logic [15:0] pix, logic [7:0] x);
        send_pixel(OP_CLASSIFY, pix, x, 3'($urandom), 16'($urandom), 24'($urandom),
                   16'($urandom));
    endtask

    // Drop valid, wait out every expected mask plus the block's longest latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (model.expected_masks.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.write_reg(idx, value);
    endtask

    task automatic set_regs(logic [15:0] a, logic [11:0] k, logic [15:0] t, logic [23:0] f);
        write_reg(CFG_LEARNING_RATE, a);
        write_reg(CFG_MATCH_SIGMAS, k);
        write_reg(CFG_BACKGROUND_WEIGHT, t);
        write_reg(CFG_VARIANCE_FLOOR, f);
    endtask

    // Load a fresh or known pixel fully, then classify it a few times, mostly near its means.
    task automatic pixel_run();
        logic [15:0] pix;
        logic [23:0] v;
        int          g;
        pix = 16'($urandom);
        for (int i = 0; i < DEF_GAUSSIANS; i++) begin
            case ($urandom_range(0, 9))
                0:       v = 24'($urandom_range(1, 24'hFFFFFF));
                1:       v = 24'($urandom_range(1, 255));
                default: v = 24'($urandom_range(256, 400000));
            endcase
            load_gauss(pix, 3'(i), 16'($urandom), v, 16'($urandom));
        end
        // noise: a load to a Gaussian slot that does not exist
        if ($urandom_range(0, 4) == 0)
            load_gauss(pix, 3'($urandom_range(DEF_GAUSSIANS, 7)), 16'($urandom),
                       24'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 6)) begin
            g = $urandom_range(0, DEF_GAUSSIANS - 1);
            if ($urandom_range(0, 4) == 0)
                classify(pix, 8'($urandom));
            else
                classify(pix, 8'(int'(model.mean_mem[int'(pix) * DEF_GAUSSIANS + g] >> 8)
                                 + $urandom_range(0, 6) - 3));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, weight ties, ignored loads, replacement.
        load_gauss(16'd0, 3'd0, 16'h0000, 24'd1, 16'h0000);
        load_gauss(16'd0, 3'd1, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        load_gauss(16'd0, 3'd2, 16'h8000, 24'd12800, 16'hFFFF);
        load_gauss(16'd0, 3'd7, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        load_gauss(16'd0, 3'd3, 16'h5555, 24'hAAAAAA, 16'h5555);
        classify(16'd0, 8'd0);
        classify(16'd0, 8'd255);
        classify(16'd0, 8'd128);
        for (int i = 0; i < 3; i++) load_gauss(16'hFFFF, 3'(i), 16'h0000, 24'd1, 16'd100);
        classify(16'hFFFF, 8'd255);
        classify(16'hFFFF, 8'd255);
        classify(16'hFFFF, 8'd0);
        classify(16'hFFFF, 8'd1);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: set_regs(16'hFFFF, 12'd0, 16'h0000, 24'd1);
                2: set_regs(16'd0, 12'hFFF, 16'hFFFF, 24'hFFFFFF);
                3: set_regs(16'd3000, 12'd768, 16'd30000, 24'd300);
                4: set_regs(16'($urandom), 12'($urandom_range(256, 1024)), 16'($urandom),
                            24'($urandom_range(1, 5000)));
                default: ;
            endcase
            quiet = (phase == 4);
            if (phase == 2) hold_req = 1'b1;
            while (sent < 20 + 180 * (phase + 1)) pixel_run();
            drain();
        end

        if (model.expected_masks.size() != 0) model.mismatches++;
        if (model.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/gmbu_pkg.sv
sv/gaussian_mixture_background_update.sv
tb/tb.sv
